>>> hw/rtl/rleib_pkg.sv
// Shared types, codes and helper functions for the run-length bitplane decoder.
`default_nettype none

package rleib_pkg;

    // Field and storage widths
    localparam int unsigned WordBits  = 64;
    localparam int unsigned ShiftW    = 7;
    localparam int unsigned CountW    = 6;
    localparam int unsigned RunLenW   = 12;
    localparam int unsigned BytesW    = 4;

    // Full word byte count
    localparam logic [BytesW-1:0] FULL_WORD_BYTES = 4'd8;

    // Input action codes
    localparam logic ACT_CODE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Plane select codes
    localparam logic PLANE_BLACK = 1'b0;
    localparam logic PLANE_RED   = 1'b1;

    // Color codes and length mode codes of a code byte
    localparam logic [1:0] COLOR_BLACK = 2'd1;
    localparam logic [1:0] COLOR_RED   = 2'd2;
    localparam logic [1:0] MODE_EXTEND = 2'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // One result handed from the sequencer to the output register
    typedef struct packed {
        logic                valid;
        logic [WordBits-1:0] word;
        logic [BytesW-1:0]   bytes;
        logic                last;
    } emit_t;

    // Pixel value of a color on the selected plane: 0 on a match, else 1
    function automatic logic pixel_of(input logic plane, input logic [1:0] color);
        logic [1:0] match;
        match = (plane == PLANE_RED) ? COLOR_RED : COLOR_BLACK;
        return (color != match);
    endfunction

    // Mask that keeps the given number of bytes from the top of a word
    function automatic logic [WordBits-1:0] top_byte_mask(input logic [2:0] bytes);
        logic [WordBits-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < int'(bytes))
            begin
                m[WordBits-1-8*i -: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rleib_in_if.sv
// Code byte channel: valid/ready handshake with action and code byte.
`default_nettype none

interface rleib_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] code_byte;

    modport source (output valid, output action, output code_byte, input ready);
    modport sink (input valid, input action, input code_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rleib_out_if.sv
// Pixel word channel: valid/ready handshake with packed pixels and byte count.
`default_nettype none

interface rleib_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] pixel_word;
    logic [3:0]  valid_bytes;
    logic        last;

    modport source (output valid, output pixel_word, output valid_bytes, output last,
                    input ready);
    modport sink (input valid, input pixel_word, input valid_bytes, input last,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rleib_shift_unit.sv
// Shared shift-and-fill unit: shifts the pending pixels left and fills the vacated bits.
`default_nettype none

module rleib_shift_unit
(
    input  wire logic [rleib_pkg::WordBits-1:0] data,
    input  wire logic [rleib_pkg::ShiftW-1:0]   amount,
    input  wire logic                           fill,
    output      logic [rleib_pkg::WordBits-1:0] result
);

    logic [rleib_pkg::WordBits-1:0] shifted;
    logic [rleib_pkg::WordBits-1:0] fill_mask;

    // Shift by up to a whole word; a shift of 64 or more drops all the data and leaves only the fill
    always_comb
    begin
        if (amount[rleib_pkg::ShiftW-1])
        begin
            shifted   = '0;
            fill_mask = '1;
        end
        else
        begin
            shifted   = data << amount[rleib_pkg::ShiftW-2:0];
            fill_mask = ~({rleib_pkg::WordBits{1'b1}} << amount[rleib_pkg::ShiftW-2:0]);
        end
        result = shifted | (fill ? fill_mask : '0);
    end

endmodule

`default_nettype wire

>>> hw/rtl/rleib_ctrl.sv
// Sequencer: decodes code bytes, steps runs through the shift unit, and flushes.
`default_nettype none

module rleib_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             plane,
    input  wire logic             in_valid,
    input  wire logic             action,
    input  wire logic [7:0]       code_byte,
    input  wire logic             out_free,
    output      logic             in_ready,
    output      rleib_pkg::emit_t emit
);

    rleib_pkg::state_t state_reg, state_next;

    logic [rleib_pkg::WordBits-1:0] pending_reg, pending_next;
    logic [rleib_pkg::CountW-1:0]   count_reg, count_next;
    logic [rleib_pkg::RunLenW-1:0]  remain_reg, remain_next;
    logic                           run_bit_reg, run_bit_next;
    logic                           awaiting_reg, awaiting_next;
    logic [1:0]                     held_color_reg, held_color_next;
    logic [3:0]                     held_high_reg, held_high_next;

    logic [rleib_pkg::ShiftW-1:0]   space;
    logic [rleib_pkg::ShiftW-1:0]   take;
    logic [rleib_pkg::ShiftW-1:0]   filled_count;
    logic                           full;
    logic [rleib_pkg::RunLenW-1:0]  remain_after;
    logic [rleib_pkg::ShiftW-1:0]   shift_amount;
    logic                           shift_fill;
    logic [rleib_pkg::WordBits-1:0] shift_result;
    logic [2:0]                     flush_bytes;
    logic                           accept;
    logic [1:0]                     code_color;
    logic [1:0]                     code_mode;
    logic [3:0]                     code_nib;

    assign in_ready = (state_reg == rleib_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign code_color = code_byte[7:6];
    assign code_mode  = code_byte[5:4];
    assign code_nib   = code_byte[3:0];

    // Size the next chunk: the rest of the run or the room left in the word
    assign space = rleib_pkg::ShiftW'(rleib_pkg::WordBits) - {1'b0, count_reg};
    assign take  = (remain_reg < {{(rleib_pkg::RunLenW-rleib_pkg::ShiftW){1'b0}}, space})
                   ? remain_reg[rleib_pkg::ShiftW-1:0] : space;
    assign filled_count = {1'b0, count_reg} + take;
    assign full         = filled_count[rleib_pkg::ShiftW-1];
    assign remain_after = remain_reg
                          - {{(rleib_pkg::RunLenW-rleib_pkg::ShiftW){1'b0}}, take};
    assign flush_bytes  = count_reg[rleib_pkg::CountW-1:3];

    // Run steps append pixels; a flush aligns the pending pixels to the top
    assign shift_amount = (state_reg == rleib_pkg::ST_FLUSH) ? space : take;
    assign shift_fill   = (state_reg == rleib_pkg::ST_FLUSH) ? 1'b0 : run_bit_reg;

    rleib_shift_unit u_shift
    (
        .data   (pending_reg),
        .amount (shift_amount),
        .fill   (shift_fill),
        .result (shift_result)
    );

    // Next-state and result logic
    always_comb
    begin
        state_next      = state_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        run_bit_next    = run_bit_reg;
        awaiting_next   = awaiting_reg;
        held_color_next = held_color_reg;
        held_high_next  = held_high_reg;

        emit.valid = 1'b0;
        emit.word  = shift_result;
        emit.bytes = rleib_pkg::FULL_WORD_BYTES;
        emit.last  = (remain_after[rleib_pkg::RunLenW-1:rleib_pkg::CountW] == '0);

        unique case (state_reg)
            rleib_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (action == rleib_pkg::ACT_FLUSH)
                    begin
                        state_next = rleib_pkg::ST_FLUSH;
                    end
                    else if (awaiting_reg)
                    begin
                        // Low count byte completes the extended run
                        awaiting_next = 1'b0;
                        remain_next   = {held_high_reg, code_byte};
                        run_bit_next  = rleib_pkg::pixel_of(plane, held_color_reg);
                        if ({held_high_reg, code_byte} != '0)
                        begin
                            state_next = rleib_pkg::ST_RUN;
                        end
                    end
                    else if (code_mode == rleib_pkg::MODE_EXTEND)
                    begin
                        // Hold the prefix until its low byte arrives
                        awaiting_next   = 1'b1;
                        held_color_next = code_color;
                        held_high_next  = code_nib;
                    end
                    else
                    begin
                        remain_next  = {{(rleib_pkg::RunLenW-4){1'b0}}, code_nib};
                        run_bit_next = rleib_pkg::pixel_of(plane, code_color);
                        if (code_nib != '0)
                        begin
                            state_next = rleib_pkg::ST_RUN;
                        end
                    end
                end
            end

            rleib_pkg::ST_RUN:
            begin
                // Advance one chunk; stall while a full word cannot be sent
                if (!full || out_free)
                begin
                    emit.valid   = full;
                    pending_next = full ? '0 : shift_result;
                    count_next   = full ? '0 : filled_count[rleib_pkg::CountW-1:0];
                    remain_next  = remain_after;
                    if (remain_after == '0)
                    begin
                        state_next = rleib_pkg::ST_IDLE;
                    end
                end
            end

            rleib_pkg::ST_FLUSH:
            begin
                // Send whole bytes, drop the partial byte and prefix, clear state
                emit.word  = shift_result & rleib_pkg::top_byte_mask(flush_bytes);
                emit.bytes = {1'b0, flush_bytes};
                emit.last  = 1'b1;
                if (flush_bytes == '0 || out_free)
                begin
                    emit.valid      = (flush_bytes != '0);
                    pending_next    = '0;
                    count_next      = '0;
                    awaiting_next   = 1'b0;
                    held_color_next = '0;
                    held_high_next  = '0;
                    state_next      = rleib_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rleib_pkg::ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rleib_pkg::ST_IDLE;
            pending_reg    <= '0;
            count_reg      <= '0;
            remain_reg     <= '0;
            run_bit_reg    <= 1'b0;
            awaiting_reg   <= 1'b0;
            held_color_reg <= '0;
            held_high_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            remain_reg     <= remain_next;
            run_bit_reg    <= run_bit_next;
            awaiting_reg   <= awaiting_next;
            held_color_reg <= held_color_next;
            held_high_reg  <= held_high_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rle_image_to_bitplane_top.sv
// Top level of the run-length image to bitplane decoder.
//
//  channel     dir   payload                               transfer when
//  code_ch     in    action, code_byte                     valid && ready
//  pixel_ch    out   pixel_word, valid_bytes, last         valid && ready
//  cfg         in    cfg_wr_data (plane select)            cfg_wr_en
//
//  A code byte that gives no pixels (extension prefix, zero run) leaves the sequencer idle.
//  Otherwise it is decoded, then the shift unit appends the run chunk by chunk, a chunk
//  ending at a word boundary or at the end of the run. A flush passes through its own
//  state, which waits while a partial result cannot be sent.
//  The code channel is ready only while the sequencer is idle.
//  A full result waits in the output register; a further word stalls the sequencer.
//  Reset clears the sequencer pixel state and the output valid flag, and selects the black plane.
`default_nettype none

module rle_image_to_bitplane_top
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    rleib_in_if.sink        code_ch,
    rleib_out_if.source     pixel_ch
);

    logic                            plane_reg;
    logic                            out_valid_reg;
    logic [rleib_pkg::WordBits-1:0]  out_word_reg;
    logic [rleib_pkg::BytesW-1:0]    out_bytes_reg;
    logic                            out_last_reg;
    logic                            out_free;
    rleib_pkg::emit_t                emit;

    assign out_free = !out_valid_reg || pixel_ch.ready;

    rleib_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .plane     (plane_reg),
        .in_valid  (code_ch.valid),
        .action    (code_ch.action),
        .code_byte (code_ch.code_byte),
        .out_free  (out_free),
        .in_ready  (code_ch.ready),
        .emit      (emit)
    );

    // Plane select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= rleib_pkg::PLANE_BLACK;
        end
        else if (cfg_wr_en)
        begin
            plane_reg <= cfg_wr_data;
        end
    end

    // Output valid: set on a new result, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: load with each new result, hold otherwise
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_word_reg  <= emit.word;
            out_bytes_reg <= emit.bytes;
            out_last_reg  <= emit.last;
        end
    end

    assign pixel_ch.valid       = out_valid_reg;
    assign pixel_ch.pixel_word  = out_word_reg;
    assign pixel_ch.valid_bytes = out_bytes_reg;
    assign pixel_ch.last        = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rleib_checker.sv
// Port-level checks for the run-length bitplane decoder, bound to the top level.
`default_nettype none

module rleib_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_action,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_word,
    input wire logic [3:0]  out_bytes,
    input wire logic        out_last
);

    // Hold a stalled result
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Keep a stalled payload steady
    a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word) && $stable(out_bytes)
                                    && $stable(out_last))
        else $error("result payload changed while stalled");

    // An accepted flush moves the block into its flush state, where the code channel is not ready
    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action |=> !in_ready)
        else $error("input taken during a flush");

    // Only full words or a closing partial result
    a_out_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_bytes != 4'd0) && (out_bytes <= 4'd8)
                      && ((out_bytes == 4'd8) || out_last))
        else $error("bad byte count on result");

endmodule

bind rle_image_to_bitplane_top rleib_checker u_rleib_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (code_ch.valid),
    .in_ready  (code_ch.ready),
    .in_action (code_ch.action),
    .out_valid (pixel_ch.valid),
    .out_ready (pixel_ch.ready),
    .out_word  (pixel_ch.pixel_word),
    .out_bytes (pixel_ch.valid_bytes),
    .out_last  (pixel_ch.last)
);

`default_nettype wire

>>> tb/sv/rleib_tb_pkg.sv
`timescale 1ns / 1ps
// Bitplane predictor and pixel word checker used by the decoder testbench.
package rleib_tb_pkg;
    import rleib_pkg::*;

    // One predicted pixel word transfer
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } plane_word_t;

    class bitplane_book;
        logic        plane;
        logic [63:0] acc_pixels;
        int unsigned acc_count;
        logic        ext_wait;
        logic [1:0]  ext_color;
        logic [3:0]  ext_high;
        plane_word_t due_words[$];
        int unsigned errors;

        function new();
            plane      = PLANE_BLACK;
            acc_pixels = '0;
            acc_count  = 0;
            ext_wait   = 1'b0;
            ext_color  = '0;
            ext_high   = '0;
            errors     = 0;
        endfunction

        function void set_plane(input logic value);
            plane = value;
        endfunction

        // Shift a run into the accumulator; queue every word that fills
        function void expand_run(input logic [1:0] color, input int unsigned len);
            logic        px;
            int unsigned produced;
            plane_word_t w;
            px = (color != ((plane == PLANE_RED) ? COLOR_RED : COLOR_BLACK));
            produced = 0;
            for (int unsigned i = 0; i < len; i++)
            begin
                acc_pixels = {acc_pixels[62:0], px};
                acc_count++;
                if (acc_count == 64)
                begin
                    w.word   = acc_pixels;
                    w.nbytes = FULL_WORD_BYTES;
                    w.last   = 1'b0;
                    due_words.push_back(w);
                    produced++;
                    acc_pixels = '0;
                    acc_count  = 0;
                end
            end
            // Mark the final word caused by this code byte
            if (produced > 0)
                due_words[due_words.size() - 1].last = 1'b1;
        endfunction

        // Advance the prediction by one accepted code channel transfer
        function void take_code(input logic action, input logic [7:0] code);
            int unsigned nbytes;
            plane_word_t w;
            if (action == ACT_FLUSH)
            begin
                // Emit whole bytes only, top aligned; drop the partial byte
                nbytes = acc_count / 8;
                if (nbytes > 0)
                begin
                    w.word   = (acc_pixels << (64 - acc_count))
                               & (64'hFFFF_FFFF_FFFF_FFFF << (64 - 8 * nbytes));
                    w.nbytes = nbytes[3:0];
                    w.last   = 1'b1;
                    due_words.push_back(w);
                end
                acc_pixels = '0;
                acc_count  = 0;
                ext_wait   = 1'b0;
                ext_color  = '0;
                ext_high   = '0;
            end
            else if (ext_wait)
            begin
                // Low count byte of an extended run; color maps with the current plane
                ext_wait = 1'b0;
                expand_run(ext_color, 32'({ext_high, code}));
            end
            else if (code[5:4] == MODE_EXTEND)
            begin
                ext_wait  = 1'b1;
                ext_color = code[7:6];
                ext_high  = code[3:0];
            end
            else
            begin
                expand_run(code[7:6], 32'(code[3:0]));
            end
        endfunction

        // Compare one accepted pixel word transfer with the oldest prediction
        function void check_word(input logic [63:0] word, input logic [3:0] nbytes,
                                 input logic last);
            plane_word_t w;
            if (due_words.size() == 0)
            begin
                $error("unexpected pixel word %h (valid_bytes %0d, last %0d)",
                       word, nbytes, last);
                errors++;
                return;
            end
            w = due_words.pop_front();
            if (word !== w.word)
            begin
                $error("pixel_word: expected %h, actual %h", w.word, word);
                errors++;
            end
            if (nbytes !== w.nbytes)
            begin
                $error("valid_bytes: expected %0d, actual %0d", w.nbytes, nbytes);
                errors++;
            end
            if (last !== w.last)
            begin
                $error("last: expected %0d, actual %0d", w.last, last);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top-level testbench of the run-length image to bitplane decoder.
module tb;
    import rleib_pkg::*;
    import rleib_tb_pkg::*;

    localparam int unsigned ItemsPerPhase = 50;
    localparam int unsigned RandomPhases  = 7;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned TailCycles    = 32;

    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_BURSTY
    } rx_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    rleib_in_if  code_if ();
    rleib_out_if pixel_if ();

    bitplane_book book;

    rle_image_to_bitplane_top DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .code_ch     (code_if),
        .pixel_ch    (pixel_if)
    );

    always #5 clk = ~clk;

    // Bound the run
    initial
    begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Sink pixel words; stall in windows of differing density
    initial
    begin : pixel_sink
        int unsigned cycle_no;
        int unsigned hold_left;
        rx_mode_t    rx_mode;
        pixel_if.ready = 1'b0;
        cycle_no  = 0;
        hold_left = 0;
        rx_mode   = RX_OPEN;
        forever
        begin
            @(posedge clk);
            if (rst_n && pixel_if.valid && pixel_if.ready)
                book.check_word(pixel_if.pixel_word, pixel_if.valid_bytes, pixel_if.last);
            if (cycle_no % 160 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            cycle_no++;
            case (rx_mode)
                RX_OPEN:
                    pixel_if.ready <= 1'b1;
                RX_COIN:
                    pixel_if.ready <= ($urandom_range(0, 1) == 1);
                default:
                begin
                    if (hold_left > 0)
                    begin
                        hold_left--;
                        pixel_if.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        hold_left = $urandom_range(1, 20);
                        pixel_if.ready <= 1'b0;
                    end
                    else
                    begin
                        pixel_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Present one item and hold it until the transfer
    task automatic send_code(input logic action, input logic [7:0] code);
        code_if.valid     <= 1'b1;
        code_if.action    <= action;
        code_if.code_byte <= code;
        @(posedge clk);
        while (!code_if.ready)
            @(posedge clk);
        book.take_code(action, code);
    endtask

    // Drop valid, drain every due word, then let the sequencer finish
    task automatic settle();
        code_if.valid <= 1'b0;
        @(posedge clk);
        while (book.due_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_plane(input logic value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        book.set_plane(value);
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned gap;
        int unsigned burst_left;
        int unsigned burst_max;
        int unsigned gap_max;
        logic [7:0]  code;
        logic        flush_it;
        logic        low_due;
        logic        plane;

        book = new();
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        code_if.valid     = 1'b0;
        code_if.action    = ACT_CODE;
        code_if.code_byte = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every color and length mode on the black plane
        write_plane(PLANE_BLACK);
        send_code(ACT_FLUSH, 8'h00);   // nothing pending
        send_code(ACT_CODE, 8'h0F);    // white run
        send_code(ACT_CODE, 8'h4F);    // black run
        send_code(ACT_CODE, 8'h8F);    // red run
        send_code(ACT_CODE, 8'hCF);    // color three
        send_code(ACT_CODE, 8'h2A);    // mode two, fills a word
        send_code(ACT_CODE, 8'hF7);    // color three, mode three
        send_code(ACT_CODE, 8'h00);    // zero length
        send_code(ACT_CODE, 8'h40);
        send_code(ACT_CODE, 8'h50);    // extension prefix; the next byte makes an extended run of 0
        send_code(ACT_CODE, 8'h00);
        send_code(ACT_FLUSH, 8'hFF);   // partial byte dropped
        send_code(ACT_CODE, 8'h5F);    // longest extended run
        send_code(ACT_CODE, 8'hFF);
        send_code(ACT_FLUSH, 8'h00);
        send_code(ACT_CODE, 8'h93);    // dangling prefix, then flush
        send_code(ACT_FLUSH, 8'h5A);
        send_code(ACT_CODE, 8'h4C);
        send_code(ACT_FLUSH, 8'h00);

        // Switch planes between an extension prefix and its low count byte
        send_code(ACT_CODE, 8'h9F);
        settle();
        write_plane(PLANE_RED);
        send_code(ACT_CODE, 8'hFF);
        send_code(ACT_CODE, 8'h8F);
        send_code(ACT_CODE, 8'hCF);
        send_code(ACT_CODE, 8'h4F);
        send_code(ACT_FLUSH, 8'h00);

        // Random phases, each on its own plane setting
        low_due = 1'b0;
        for (int unsigned phase = 0; phase < RandomPhases; phase++)
        begin
            settle();
            if (phase == 0)
                plane = PLANE_BLACK;
            else if (phase == 1)
                plane = PLANE_RED;
            else
                plane = logic'($urandom_range(0, 1));
            write_plane(plane);
            if (phase == 2)
            begin
                burst_max = 1000;
                gap_max   = 0;
            end
            else
            begin
                burst_max = $urandom_range(1, 16);
                gap_max   = $urandom_range(1, 12);
            end
            burst_left = $urandom_range(1, burst_max);

            for (int unsigned n = 0; n < ItemsPerPhase; n++)
            begin
                pick     = $urandom_range(0, 99);
                flush_it = 1'b0;
                code     = 8'($urandom_range(0, 255));
                if (low_due)
                begin
                    // Low count byte, now and then broken by a flush
                    flush_it = (pick < 10);
                    low_due  = 1'b0;
                end
                else if (pick < 5)
                begin
                    flush_it = 1'b1;
                end
                else
                begin
                    if (pick < 20)
                        code[5:4] = MODE_EXTEND;
                    // Keep most extended runs short
                    if (code[5:4] == MODE_EXTEND)
                    begin
                        low_due = 1'b1;
                        if ($urandom_range(0, 9) != 0)
                            code[3:1] = 3'b000;
                    end
                end
                send_code(flush_it ? ACT_FLUSH : ACT_CODE, code);

                // Close the burst and idle for a while
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, burst_max);
                    gap = $urandom_range(0, gap_max);
                    if (gap > 0)
                    begin
                        code_if.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        // Drain and report
        settle();
        repeat (TailCycles) @(posedge clk);
        if (book.due_words.size() != 0)
        begin
            $error("%0d pixel words never arrived", book.due_words.size());
            book.errors++;
        end
        if (book.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rleib_pkg.sv
hw/rtl/rleib_in_if.sv
hw/rtl/rleib_out_if.sv
hw/rtl/rleib_shift_unit.sv
hw/rtl/rleib_ctrl.sv
hw/rtl/rle_image_to_bitplane_top.sv
hw/rtl/rleib_checker.sv
tb/sv/rleib_tb_pkg.sv
tb/sv/tb.sv
